/* hdl/dlr_pkg.sv */
// ----------------------------------------------------------------------------
// dlr_pkg: shared types and constants of the down-mixing resampler
// Beat layouts, fixed-point widths, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package dlr_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int FRAC_BITS    = 16;

   localparam int SAMPLE_W    = 16;
   localparam int CC_REG_W    = 4;
   localparam int STEP_REG_W  = 20;
   localparam int CSR_DATA_W  = 20;
   localparam int CSR_INDEX_W = 1;

   // Channel position, frame accumulator and divisor widths.
   localparam int CPOS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int SUM_W  = SAMPLE_W + CPOS_W;
   localparam int DIV_W  = $clog2(MAX_CHANNELS + 1);

   // Source position: the step stays below 13 source samples.
   localparam int POS_W  = FRAC_BITS + 4;
   localparam int PROD_W = SAMPLE_W + 1 + FRAC_BITS + 1;
   localparam int Q_W    = PROD_W - FRAC_BITS;

   localparam logic [POS_W-1:0] ONE_POS      = POS_W'(64'd1 << FRAC_BITS);
   localparam logic [POS_W-1:0] STEP_MIN_POS = POS_W'((64'd1 << FRAC_BITS) >> 2);
   localparam logic [POS_W-1:0] STEP_MAX_POS = POS_W'(64'd12 << FRAC_BITS);

   localparam logic [CC_REG_W-1:0]   CC_RESET   = CC_REG_W'(1);
   localparam logic [STEP_REG_W-1:0] STEP_RESET = STEP_REG_W'(65536);

   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP    = 1'b1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_in;
      logic                       end_of_stream;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       last;
      logic                       no_data;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_LOOP,
      ST_MUL,
      ST_PUSH,
      ST_FLUSH,
      ST_FINAL
   } state_type;

endpackage

/* hdl/dlr_divider.sv */
// ----------------------------------------------------------------------------
// dlr_divider: iterative frame-average divider
// Restoring division of the signed frame sum by the channel count, one
// quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module dlr_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [dlr_pkg::SUM_W-1:0]    dividend,
   input  logic        [dlr_pkg::DIV_W-1:0]    divisor,
   output logic                                done,
   output logic signed [dlr_pkg::SAMPLE_W-1:0] quotient
);
   import dlr_pkg::*;

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic                busy_ff;
   logic                done_ff;
   logic                neg_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [SUM_W-1:0]    work_ff;
   logic [SUM_W-1:0]    work_in;
   logic [DIV_W-1:0]    rem_ff;
   logic [DIV_W-1:0]    rem_in;
   logic [DIV_W:0]      rem_shift;
   logic                fits;
   logic [SUM_W-1:0]    magnitude;
   logic [SUM_W-1:0]    result;

   assign magnitude = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);

   always_comb begin
      rem_shift = {rem_ff, work_ff[SUM_W-1]};
      fits      = rem_shift >= (DIV_W + 1)'(divisor);
      rem_in    = fits ? DIV_W'(rem_shift - (DIV_W + 1)'(divisor)) : DIV_W'(rem_shift);
      work_in   = {work_ff[SUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && count_ff == CNT_W'(SUM_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         count_ff <= '0;
         work_ff  <= magnitude;
         rem_ff   <= '0;
         neg_ff   <= dividend[SUM_W-1];
      end else if (busy_ff) begin
         count_ff <= count_ff + CNT_W'(1);
         work_ff  <= work_in;
         rem_ff   <= rem_in;
      end
   end

   assign result   = neg_ff ? -work_ff : work_ff;
   assign quotient = signed'(result[SAMPLE_W-1:0]);
   assign done     = done_ff;

endmodule

/* hdl/dlr_interp.sv */
// ----------------------------------------------------------------------------
// dlr_interp: linear interpolation unit
// Registers the difference times the fractional position, then rounds to
// nearest (halves upward) and adds the earlier sample.
// ----------------------------------------------------------------------------
module dlr_interp (
   input  logic                                clock,
   input  logic signed [dlr_pkg::SAMPLE_W-1:0] sample_a,
   input  logic signed [dlr_pkg::SAMPLE_W-1:0] sample_b,
   input  logic        [dlr_pkg::FRAC_BITS-1:0] frac,
   output logic signed [dlr_pkg::SAMPLE_W-1:0] value
);
   import dlr_pkg::*;

   logic signed [SAMPLE_W:0]    diff;
   logic signed [FRAC_BITS:0]   frac_s;
   logic signed [PROD_W-1:0]    product_in;
   logic signed [PROD_W-1:0]    product_ff;
   logic signed [PROD_W-1:0]    rounded;
   logic signed [Q_W-1:0]       step_q;
   logic signed [Q_W-1:0]       total;

   assign diff       = (SAMPLE_W + 1)'(sample_b) - (SAMPLE_W + 1)'(sample_a);
   assign frac_s     = signed'({1'b0, frac});
   assign product_in = PROD_W'(diff) * PROD_W'(frac_s);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign rounded = product_ff + PROD_W'(64'd1 << (FRAC_BITS - 1));
   assign step_q  = signed'(rounded[PROD_W-1:FRAC_BITS]);
   assign total   = Q_W'(sample_a) + step_q;
   assign value   = signed'(total[SAMPLE_W-1:0]);

endmodule

/* hdl/downmix_linear_resampler.sv */
// ----------------------------------------------------------------------------
// downmix_linear_resampler: down-mix to mono and resample to 16 kHz
// Interleaved signed Q1.15 samples arrive one per request beat; every
// channel_count beats form a frame whose truncated average is one mono
// sample, and the mono stream is linearly interpolated at source positions
// spaced by phase_step (unsigned Q4.16, input rate over 16000, saturated to
// 0.25..12). A beat with end_of_stream set carries no sample: it flushes the
// outputs still due using the last mono sample at both ends, and the final
// response beat carries last; an end beat with no complete frame gives one
// response with no_data and last set. An incomplete final frame is dropped,
// and the stream state returns to its reset values after the end beat while
// the registers keep theirs. A sample that does not close a frame is only
// added to the frame sum; a frame-closing sample goes through the bit-serial
// divider that forms the average, then each interpolated output passes the
// loop, multiply and push states through the shared multiplier. The end beat
// passes the flush state, one flushed output at a time, then the final state.
// Request ready is low while a beat is being worked on; a response register
// lets the block go on while a finished response waits to be taken, and the
// sequencer stalls only when it must hand a second one over. Configuration
// writes are taken at once and must only be made while the block is idle.
// ----------------------------------------------------------------------------
module downmix_linear_resampler (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [dlr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dlr_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  dlr_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output dlr_pkg::rsp_type                   rsp_data
);
   import dlr_pkg::*;

   localparam int CMP_W = DIV_W + 1;

   // Configuration registers.
   logic [CC_REG_W-1:0]          channel_count_ff;
   logic [STEP_REG_W-1:0]        phase_step_ff;

   // Stream state.
   state_type                    state_ff, state_in;
   logic [CPOS_W-1:0]            chan_pos_ff, chan_pos_in;
   logic signed [SUM_W-1:0]      frame_sum_ff, frame_sum_in;
   logic signed [SAMPLE_W-1:0]   prev_mono_ff, prev_mono_in;
   logic signed [SAMPLE_W-1:0]   cur_mono_ff, cur_mono_in;
   logic                         mono_seen_ff, mono_seen_in;
   logic [POS_W-1:0]             next_pos_ff, next_pos_in;
   logic                         pend_valid_ff, pend_valid_in;
   logic signed [SAMPLE_W-1:0]   pend_value_ff, pend_value_in;

   // Response register.
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_data_ff, rsp_data_in;

   logic [DIV_W-1:0]             cc_eff;
   logic [POS_W-1:0]             step_eff;
   logic [CMP_W-1:0]             pos_plus_one;
   logic                         frame_more;
   logic signed [SUM_W-1:0]      sum_new;
   logic                         req_fire;
   logic                         out_free;
   logic                         pos_due;
   logic                         div_start;
   logic                         div_done;
   logic signed [SAMPLE_W-1:0]   div_quotient;
   logic signed [SAMPLE_W-1:0]   interp_value;

   // Out-of-range channel counts are taken as the nearest legal value.
   always_comb begin
      if (channel_count_ff == '0) begin
         cc_eff = DIV_W'(1);
      end else if (int'(channel_count_ff) > MAX_CHANNELS) begin
         cc_eff = DIV_W'(MAX_CHANNELS);
      end else begin
         cc_eff = DIV_W'(channel_count_ff);
      end
   end

   // The phase step saturates to a quarter and twelve source samples.
   always_comb begin
      if (64'(phase_step_ff) < 64'(STEP_MIN_POS)) begin
         step_eff = STEP_MIN_POS;
      end else if (64'(phase_step_ff) > 64'(STEP_MAX_POS)) begin
         step_eff = STEP_MAX_POS;
      end else begin
         step_eff = POS_W'(phase_step_ff);
      end
   end

   assign pos_plus_one = CMP_W'(chan_pos_ff) + CMP_W'(1);
   assign frame_more   = pos_plus_one < CMP_W'(cc_eff);
   assign sum_new      = frame_sum_ff + SUM_W'(req_data.sample_in);
   assign req_fire     = req_valid && req_ready;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign pos_due      = next_pos_ff < ONE_POS;

   dlr_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_new),
      .divisor  (cc_eff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   dlr_interp u_interp (
      .clock    (clock),
      .sample_a (prev_mono_ff),
      .sample_b (cur_mono_ff),
      .frac     (next_pos_ff[FRAC_BITS-1:0]),
      .value    (interp_value)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.end_of_stream) begin
                  state_in = mono_seen_ff ? ST_FLUSH : ST_FINAL;
               end else if (!frame_more) begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = mono_seen_ff ? ST_LOOP : ST_IDLE;
            end
         end
         ST_LOOP: begin
            state_in = pos_due ? ST_MUL : ST_IDLE;
         end
         ST_MUL: begin
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = ST_LOOP;
            end
         end
         ST_FLUSH: begin
            if (!pos_due) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath updates and handshake outputs.
   always_comb begin
      req_ready     = 1'b0;
      div_start     = 1'b0;
      chan_pos_in   = chan_pos_ff;
      frame_sum_in  = frame_sum_ff;
      prev_mono_in  = prev_mono_ff;
      cur_mono_in   = cur_mono_ff;
      mono_seen_in  = mono_seen_ff;
      next_pos_in   = next_pos_ff;
      pend_valid_in = pend_valid_ff;
      pend_value_in = pend_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire && !req_data.end_of_stream) begin
               if (frame_more) begin
                  frame_sum_in = sum_new;
                  chan_pos_in  = chan_pos_ff + CPOS_W'(1);
               end else begin
                  div_start    = 1'b1;
                  frame_sum_in = '0;
                  chan_pos_in  = '0;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               if (!mono_seen_ff) begin
                  mono_seen_in = 1'b1;
                  prev_mono_in = div_quotient;
                  cur_mono_in  = div_quotient;
                  next_pos_in  = '0;
               end else begin
                  prev_mono_in = cur_mono_ff;
                  cur_mono_in  = div_quotient;
               end
            end
         end
         ST_LOOP: begin
            // Past the current mono sample: rebase on the next one.
            if (!pos_due) begin
               next_pos_in = next_pos_ff - ONE_POS;
            end
         end
         ST_MUL: begin
         end
         ST_PUSH: begin
            // Each new value is held back by one so the final one can carry last.
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in           = 1'b1;
                  rsp_data_in.sample_out = pend_value_ff;
                  rsp_data_in.last       = 1'b0;
                  rsp_data_in.no_data    = 1'b0;
               end
               pend_value_in = interp_value;
               pend_valid_in = 1'b1;
               next_pos_in   = next_pos_ff + step_eff;
            end
         end
         ST_FLUSH: begin
            // Outputs still due at the end use the last mono sample at both ends.
            if (pos_due && (!pend_valid_ff || out_free)) begin
               if (pend_valid_ff) begin
                  rsp_valid_in           = 1'b1;
                  rsp_data_in.sample_out = pend_value_ff;
                  rsp_data_in.last       = 1'b0;
                  rsp_data_in.no_data    = 1'b0;
               end
               pend_value_in = cur_mono_ff;
               pend_valid_in = 1'b1;
               next_pos_in   = next_pos_ff + step_eff;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.sample_out = mono_seen_ff ? pend_value_ff : '0;
               rsp_data_in.last       = 1'b1;
               rsp_data_in.no_data    = !mono_seen_ff;
               chan_pos_in            = '0;
               frame_sum_in           = '0;
               prev_mono_in           = '0;
               cur_mono_in            = '0;
               mono_seen_in           = 1'b0;
               next_pos_in            = '0;
               pend_valid_in          = 1'b0;
               pend_value_in          = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff <= CC_RESET;
         phase_step_ff    <= STEP_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_CHANNEL_COUNT) begin
            channel_count_ff <= csr_write_data[CC_REG_W-1:0];
         end
         if (csr_index == CSR_PHASE_STEP) begin
            phase_step_ff <= csr_write_data[STEP_REG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         chan_pos_ff   <= '0;
         frame_sum_ff  <= '0;
         prev_mono_ff  <= '0;
         cur_mono_ff   <= '0;
         mono_seen_ff  <= 1'b0;
         next_pos_ff   <= '0;
         pend_valid_ff <= 1'b0;
         pend_value_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         chan_pos_ff   <= chan_pos_in;
         frame_sum_ff  <= frame_sum_in;
         prev_mono_ff  <= prev_mono_in;
         cur_mono_ff   <= cur_mono_in;
         mono_seen_ff  <= mono_seen_in;
         next_pos_ff   <= next_pos_in;
         pend_valid_ff <= pend_valid_in;
         pend_value_ff <= pend_value_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* tb/downmix_linear_resampler_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// downmix_linear_resampler_checker: response predictor and scoreboard
// Watches the register port and both beat channels of the resampler, works
// out the response beats due for every accepted request beat and compares
// each accepted response beat with the oldest one still awaited.
// ----------------------------------------------------------------------------
module downmix_linear_resampler_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [dlr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dlr_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  dlr_pkg::req_type                req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  dlr_pkg::rsp_type                rsp_data,
   output int                              mismatch_count,
   output int                              awaited_count,
   output int                              checked_count
);
   import dlr_pkg::*;

   localparam int unsigned UNIT_POS     = 1 << FRAC_BITS;
   localparam int          REPORT_LIMIT = 10;

   logic [CC_REG_W-1:0]        mix_channels;
   logic [STEP_REG_W-1:0]      mix_step;

   int unsigned                slot;
   int                         frame_total;
   int                         older_mono;
   int                         newest_mono;
   bit                         have_mono;
   int unsigned                position;
   bit                         held_valid;
   logic signed [SAMPLE_W-1:0] held_value;

   rsp_type                    expected_samples[$];
   int                         errors  = 0;
   int                         checked = 0;

   task automatic clear_stream();
      slot        = 0;
      frame_total = 0;
      older_mono  = 0;
      newest_mono = 0;
      have_mono   = 1'b0;
      position    = 0;
      held_valid  = 1'b0;
      held_value  = '0;
   endtask

   task automatic expect_beat(input logic signed [SAMPLE_W-1:0] value, input logic last,
                              input logic no_data);
      rsp_type r;
      r.sample_out = value;
      r.last       = last;
      r.no_data    = no_data;
      expected_samples.push_back(r);
   endtask

   // Every output is held back by one so that the final one can carry last.
   task automatic mix_and_resample(input req_type beat);
      int unsigned step;
      int unsigned divisor;
      int          mono;
      longint      delta;
      step = mix_step;
      if (step < STEP_MIN_POS) step = STEP_MIN_POS;
      if (step > STEP_MAX_POS) step = STEP_MAX_POS;
      divisor = (mix_channels == 0) ? 1 :
                (mix_channels > MAX_CHANNELS) ? MAX_CHANNELS : mix_channels;
      if (beat.end_of_stream) begin
         if (!have_mono) begin
            expect_beat('0, 1'b1, 1'b1);
         end else begin
            while (position < UNIT_POS) begin
               if (held_valid) expect_beat(held_value, 1'b0, 1'b0);
               held_value = SAMPLE_W'(newest_mono);
               held_valid = 1'b1;
               position += step;
            end
            expect_beat(held_value, 1'b1, 1'b0);
         end
         clear_stream();
      end else begin
         frame_total += int'(beat.sample_in);
         if (slot + 1 < divisor) begin
            slot++;
         end else begin
            mono        = frame_total / int'(divisor);
            frame_total = 0;
            slot        = 0;
            if (!have_mono) begin
               have_mono   = 1'b1;
               older_mono  = mono;
               newest_mono = mono;
               position    = 0;
            end else begin
               older_mono  = newest_mono;
               newest_mono = mono;
               while (position < UNIT_POS) begin
                  delta = longint'(newest_mono) - longint'(older_mono);
                  if (held_valid) expect_beat(held_value, 1'b0, 1'b0);
                  held_value = SAMPLE_W'(longint'(older_mono) +
                     ((delta * longint'(position) + (longint'(1) << (FRAC_BITS - 1)))
                      >>> FRAC_BITS));
                  held_valid = 1'b1;
                  position += step;
               end
               position -= UNIT_POS;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         mix_channels = CC_RESET;
         mix_step     = STEP_RESET;
         clear_stream();
         expected_samples.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_CHANNEL_COUNT: mix_channels = csr_write_data[CC_REG_W-1:0];
               CSR_PHASE_STEP:    mix_step     = csr_write_data[STEP_REG_W-1:0];
               default: ;
            endcase
         end
         // Requests first: a response never leaves in the cycle its request arrives.
         if (req_valid && req_ready) mix_and_resample(req_data);
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (expected_samples.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("unexpected response beat: sample %0d last %0b no_data %0b",
                           rsp_data.sample_out, rsp_data.last, rsp_data.no_data);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_data.sample_out !== want.sample_out || rsp_data.last !== want.last ||
                   rsp_data.no_data !== want.no_data) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display({"response mismatch: expected sample %0d last %0b no_data %0b,",
                               " got sample %0d last %0b no_data %0b"},
                              want.sample_out, want.last, want.no_data,
                              rsp_data.sample_out, rsp_data.last, rsp_data.no_data);
               end
            end
         end
      end
      mismatch_count <= errors;
      awaited_count  <= expected_samples.size();
      checked_count  <= checked;
   end

endmodule

/* tb/downmix_linear_resampler_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// downmix_linear_resampler_test: stimulus and verdict for the resampler
// Drives interleaved sample streams, each closed by an end beat, through the
// block under a series of channel counts and phase steps, with random gaps on
// the request side and random stalls on the response side. A checker beside
// the block predicts and compares every response beat.
// ----------------------------------------------------------------------------
module downmix_linear_resampler_test;
   import dlr_pkg::*;

   localparam int RANDOM_BEATS   = 370;
   localparam int IDLE_PERCENT   = 8;
   localparam int SETTLE_CYCLES  = 100;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   req_type                req_data         = '0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   rsp_type                rsp_data;

   int                     mismatch_count;
   int                     awaited_count;
   int                     checked_count;

   bit                     idling_on     = 1'b1;
   int                     quiet_cycles  = 0;
   int                     beats_sent    = 0;
   int                     streams_sent  = 0;
   int                     settings_used = 1;
   logic [CC_REG_W-1:0]    channels_reg  = CC_RESET;

   always #5 clock = ~clock;

   downmix_linear_resampler dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data)
   );

   downmix_linear_resampler_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .mismatch_count   (mismatch_count),
      .awaited_count    (awaited_count),
      .checked_count    (checked_count)
   );

   // The receiver stalls in roughly one cycle in twelve, except during the
   // quiet stretch, when it takes every response beat at once.
   always @(posedge clock) begin
      rsp_ready <= !idling_on || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // The watchdog counts cycles in which no beat moves on either channel. The
   // longest legitimate lull is the settling pause between register settings
   // plus one frame-closing division with its outputs, far below the limit.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
         $display("downmix_linear_resampler_test NOT OK");
         $finish;
      end
   end

   // Offers one request beat, sometimes after a short gap with valid low, and
   // returns at the edge where it is taken. Valid stays high between beats
   // sent back to back, so it is never lowered and raised in one time step.
   task automatic send_beat(input logic signed [SAMPLE_W-1:0] sample, input logic closing);
      req_type     beat;
      int unsigned gap;
      beat.sample_in     = sample;
      beat.end_of_stream = closing;
      if (idling_on && $urandom_range(99) < IDLE_PERCENT) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      if (closing) streams_sent++;
   endtask

   // Waits until every awaited response has arrived, then gives the block
   // time to finish any frame that closed without producing a response.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Both registers are written on consecutive edges with the enable held high.
   task automatic write_registers(input logic [CC_REG_W-1:0] channels,
                                  input logic [STEP_REG_W-1:0] step);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_CHANNEL_COUNT;
      csr_write_data   <= CSR_DATA_W'(channels);
      @(posedge clock);
      csr_index        <= CSR_PHASE_STEP;
      csr_write_data   <= CSR_DATA_W'(step);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      channels_reg = channels;
      settings_used++;
   endtask

   // Full-scale values turn up often so that the frame sums reach their limits.
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return SAMPLE_W'($urandom_range(0, 7));
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Most streams are whole frames with random content; the rest are a lone
   // end beat or an arbitrary count of samples, which may leave a cut frame.
   // End beats carry junk in the sample field, which the block must ignore.
   task automatic random_stream();
      int unsigned width;
      int unsigned count;
      int unsigned kind;
      width = (channels_reg == 0) ? 1 :
              (channels_reg > MAX_CHANNELS) ? MAX_CHANNELS : channels_reg;
      kind  = $urandom_range(99);
      if (kind < 8) begin
         count = 0;
      end else if (kind < 25) begin
         count = $urandom_range(0, 5 * width);
      end else begin
         count = width * $urandom_range(1, 5);
      end
      repeat (count) send_beat(pick_sample(), 1'b0);
      send_beat(SAMPLE_W'($urandom), 1'b1);
   endtask

   initial begin
      logic [CC_REG_W-1:0]   channels;
      logic [STEP_REG_W-1:0] step;
      int                    phase;
      int                    target;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part, first with the registers at their reset values: an
      // empty stream, then the two full-scale extremes and zero in mono.
      send_beat(16'sd0, 1'b1);
      send_beat(16'sh7FFF, 1'b0);
      send_beat(16'sh8000, 1'b0);
      send_beat(16'sd0, 1'b0);
      send_beat(16'sd0, 1'b1);
      drain();

      // Two channels at the smallest step: a stream holding only a cut frame
      // must report no data; then frames at both extremes, and a frame whose
      // sum is minus one, which truncates towards zero.
      write_registers(CC_REG_W'(2), STEP_REG_W'(STEP_MIN_POS));
      send_beat(16'sd5, 1'b0);
      send_beat(16'sd0, 1'b1);
      send_beat(16'sh7FFF, 1'b0);
      send_beat(16'sh7FFF, 1'b0);
      send_beat(16'sh8000, 1'b0);
      send_beat(16'sh8000, 1'b0);
      send_beat(16'shFFFF, 1'b0);
      send_beat(16'sd0, 1'b0);
      send_beat(16'sd0, 1'b1);
      drain();

      // Channel count above the maximum and the largest step, both of which
      // the block must saturate. The frame sums to minus four, averaging to
      // zero, and the end beat carries a non-zero sample that is ignored.
      write_registers('1, '1);
      for (int i = 0; i < 8; i++) begin
         send_beat((i % 2 == 1) ? 16'sh7FFF : 16'sh8000, 1'b0);
      end
      send_beat(16'sh8001, 1'b1);
      drain();

      // Channel count zero is taken as one, and a zero step is raised to the minimum.
      write_registers('0, '0);
      send_beat(-16'sd7, 1'b0);
      send_beat(16'sd7, 1'b0);
      send_beat(16'sd0, 1'b1);
      drain();

      // Random part: each phase picks a register setting, sends a few streams
      // and drains before the next write. Phases three to five run with no
      // idling on either side.
      phase  = 0;
      target = beats_sent + RANDOM_BEATS;
      while (beats_sent < target) begin
         idling_on <= !(phase >= 3 && phase < 6);
         case ($urandom_range(9))
            0:       channels = '0;
            1:       channels = CC_REG_W'($urandom_range(MAX_CHANNELS + 1, 15));
            2:       channels = CC_REG_W'(MAX_CHANNELS);
            3:       channels = CC_REG_W'(1);
            default: channels = CC_REG_W'($urandom_range(1, MAX_CHANNELS));
         endcase
         // Whole kHz rates map exactly onto 4096 step units per kHz.
         case ($urandom_range(9))
            0:       step = STEP_REG_W'(STEP_MIN_POS);
            1:       step = STEP_REG_W'(STEP_MAX_POS);
            2:       step = STEP_REG_W'($urandom_range(0, STEP_MIN_POS - 1));
            3:       step = STEP_REG_W'($urandom_range(STEP_MAX_POS + 1,
                                                       (1 << STEP_REG_W) - 1));
            4, 5:    step = STEP_REG_W'($urandom_range(8, 192) * 4096);
            default: step = STEP_REG_W'($urandom_range(STEP_MIN_POS, STEP_MAX_POS));
         endcase
         write_registers(channels, step);
         repeat ($urandom_range(1, 3)) random_stream();
         drain();
         phase++;
      end

      $display("Run summary: %0d request beats in %0d streams under %0d register settings,",
               beats_sent, streams_sent, settings_used);
      $display("%0d response beats compared, %0d mismatching.", checked_count, mismatch_count);
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("downmix_linear_resampler_test OK");
      end else begin
         $display("downmix_linear_resampler_test NOT OK");
      end
      $finish;
   end

endmodule
